>>> rtl/core/dqtc_pkg.sv
// Package for the device quota transfer checker.
// Holds field widths, beat layouts, status and register codes and the sequencer states.
// Depends on nothing; used by device_quota_transfer_checker and its testbench.
package dqtc_pkg;

  // Fixed field widths of the stream beats.
  localparam int unsigned DevIdxW    = 2;
  localparam int unsigned AmountW    = 48;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned LimitW     = 48;
  localparam int unsigned NumLimits  = 4;
  localparam int unsigned CfgIdxW    = 3;

  // Beat widths, padded to whole bytes.
  localparam int unsigned InDataW    = 104;
  localparam int unsigned OutDataW   = 104;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STS_OK             = 3'd0,
    STS_DEST_LIMIT     = 3'd1,
    STS_POOL_LIMIT     = 3'd2,
    STS_SRC_UNDERFLOW  = 3'd3,
    STS_POOL_UNDERFLOW = 3'd4,
    STS_DEST_OVERFLOW  = 3'd5,
    STS_POOL_OVERFLOW  = 3'd6
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POOL_LIMIT  = 3'd0,
    CFG_DEV_LIMIT_0 = 3'd1,
    CFG_DEV_LIMIT_1 = 3'd2,
    CFG_DEV_LIMIT_2 = 3'd3,
    CFG_DEV_LIMIT_3 = 3'd4
  } cfg_idx_e;

  // Sequencer states: read source, read destination, add, check, write back.
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RD_DST,
    FSM_SUM,
    FSM_DECIDE,
    FSM_WR_SRC,
    FSM_WR_DST
  } fsm_e;

endpackage

>>> rtl/core/device_quota_transfer_checker.sv
// Device quota transfer checker: per-device usage counters in a RAM, one pool counter.
// Depends on dqtc_pkg and dqtc_ram.
//
//   Channel | Direction | Handshake               | Content
//   s_axis  | in        | s_axis_tvalid/tready    | transfer request, commit flag in tuser
//   m_axis  | out       | m_axis_tvalid/tready    | status, destination usage, pool usage
//   cfg     | in        | cfg_we_i (no wait)      | pool limit and four device limits
//
// A result beat is loaded at the end of the sequence that follows an accepted request: the
// source read starts at the accepting edge, then come the destination read, an add stage,
// a check stage and one write each for the source and destination counters on the usage
// RAM's write port. Only after the load does it return to idle and accept the next request.
// A result still waiting at the output holds the sequencer in its last state and stalls input.
// Reset clears all counters at once through per-device valid bits; no clearing pass is needed.
module device_quota_transfer_checker #(
  parameter int unsigned NUM_DEVICES = 4,
  parameter int unsigned COUNT_BITS  = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request beats.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] source_device, [49:2] source_amount, [51:50] dest_device,
  // [99:52] dest_amount, [103:100] zero
  input  logic [dqtc_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] apply_change
  input  logic                          s_axis_tuser,
  // Result beats.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [50:3] dest_usage, [98:51] pool_usage, [103:99] zero
  output logic [dqtc_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [dqtc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dqtc_pkg::LimitW-1:0]   cfg_data_i
);

  localparam int unsigned AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  // Sum width: wide enough for any counter plus any amount, plus a carry.
  localparam int unsigned SW = ((COUNT_BITS > dqtc_pkg::AmountW) ?
                                COUNT_BITS : dqtc_pkg::AmountW) + 1;
  // Output view width: counter widened to at least the field width.
  localparam int unsigned VW = (COUNT_BITS > dqtc_pkg::AmountW) ?
                               COUNT_BITS : dqtc_pkg::AmountW;
  localparam logic [SW-1:0] CntMax = {{(SW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  // Clamp a device field to the last implemented device.
  function automatic logic [AW-1:0] clamp_dev(input logic [dqtc_pkg::DevIdxW-1:0] dev);
    logic [dqtc_pkg::DevIdxW:0] dev_x;
    dev_x = {1'b0, dev};
    if (dev_x >= (dqtc_pkg::DevIdxW+1)'(NUM_DEVICES)) begin
      return AW'(NUM_DEVICES - 1);
    end
    return AW'(dev);
  endfunction

  // Counter to result field: low field bits, zero-extended when the counter is narrower.
  function automatic logic [dqtc_pkg::AmountW-1:0] to_field(input logic [COUNT_BITS-1:0] v);
    logic [VW-1:0] v_x;
    v_x = VW'(v);
    return v_x[dqtc_pkg::AmountW-1:0];
  endfunction

  // Control state.
  dqtc_pkg::fsm_e state_q, state_d;
  logic [NUM_DEVICES-1:0] vld_q;
  logic [COUNT_BITS-1:0]  pool_q;
  logic                   m_valid_q;

  // Configuration registers.
  logic [dqtc_pkg::LimitW-1:0] pool_lim_q;
  logic [dqtc_pkg::LimitW-1:0] dev_lim_q [dqtc_pkg::NumLimits];

  // Request and working registers.
  logic [AW-1:0]                 sd_q, td_q;
  logic [dqtc_pkg::AmountW-1:0]  from_q, to_q;
  logic                          apply_q;
  logic [COUNT_BITS-1:0]         src_q, dst_q;
  logic [dqtc_pkg::AmountW-1:0]  tgain_q, pgain_q;
  logic [SW-1:0]                 dsum_q, psum_q;
  logic                          src_uf_q, pool_uf_q;
  dqtc_pkg::status_e             status_q, status_d;
  logic                          commit_q;
  logic [COUNT_BITS-1:0]         new_src_q, new_dst_q, new_pool_q;
  logic [dqtc_pkg::OutDataW-1:0] m_data_q;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  logic                  has_src, has_dst, same_dev, out_free, out_load, accept;
  logic [COUNT_BITS-1:0] rd_src, rd_dst;
  logic [1:0]            td_lim;
  logic [dqtc_pkg::LimitW-1:0] dst_lim;

  dqtc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_DEVICES)
  ) u_usage_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Request decode from the captured beat.
  assign has_src  = (from_q != '0);
  assign has_dst  = (to_q != '0);
  assign same_dev = has_src && has_dst && (sd_q == td_q);
  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // A counter never written since reset reads as zero.
  assign rd_src = vld_q[sd_q] ? ram_rdata : '0;
  assign rd_dst = vld_q[td_q] ? ram_rdata : '0;

  assign td_lim  = 2'(td_q);
  assign dst_lim = dev_lim_q[td_lim];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dqtc_pkg::FSM_IDLE: begin
        if (s_axis_tvalid) state_d = dqtc_pkg::FSM_RD_DST;
      end
      dqtc_pkg::FSM_RD_DST: state_d = dqtc_pkg::FSM_SUM;
      dqtc_pkg::FSM_SUM:    state_d = dqtc_pkg::FSM_DECIDE;
      dqtc_pkg::FSM_DECIDE: state_d = dqtc_pkg::FSM_WR_SRC;
      dqtc_pkg::FSM_WR_SRC: state_d = dqtc_pkg::FSM_WR_DST;
      dqtc_pkg::FSM_WR_DST: begin
        if (out_free) state_d = dqtc_pkg::FSM_IDLE;
      end
      default: state_d = dqtc_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, RAM ports and result load.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = td_q;
    ram_wdata     = new_dst_q;
    ram_raddr     = td_q;
    out_load      = 1'b0;
    case (state_q)
      dqtc_pkg::FSM_IDLE: begin
        s_axis_tready = 1'b1;
        ram_raddr     = clamp_dev(s_axis_tdata[1:0]);
      end
      dqtc_pkg::FSM_WR_SRC: begin
        ram_we    = commit_q && has_src && !same_dev;
        ram_waddr = sd_q;
        ram_wdata = new_src_q;
      end
      dqtc_pkg::FSM_WR_DST: begin
        ram_we   = commit_q && has_dst && out_free;
        out_load = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Check order: faults first, then destination limit, then pool limit.
  always_comb begin
    status_d = dqtc_pkg::STS_OK;
    if (src_uf_q) begin
      status_d = dqtc_pkg::STS_SRC_UNDERFLOW;
    end else if (pool_uf_q) begin
      status_d = dqtc_pkg::STS_POOL_UNDERFLOW;
    end else if (has_dst && (dsum_q > CntMax)) begin
      status_d = dqtc_pkg::STS_DEST_OVERFLOW;
    end else if (psum_q > CntMax) begin
      status_d = dqtc_pkg::STS_POOL_OVERFLOW;
    end else if (has_dst && (tgain_q != '0) && (dst_lim != '0) &&
                 (dsum_q > SW'(dst_lim))) begin
      status_d = dqtc_pkg::STS_DEST_LIMIT;
    end else if ((pgain_q != '0) && (pool_lim_q != '0) && (psum_q > SW'(pool_lim_q))) begin
      status_d = dqtc_pkg::STS_POOL_LIMIT;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dqtc_pkg::FSM_IDLE;
      vld_q     <= '0;
      pool_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (out_load && commit_q) begin
        pool_q <= new_pool_q;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_lim_q <= '0;
      for (int i = 0; i < dqtc_pkg::NumLimits; i++) begin
        dev_lim_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dqtc_pkg::CFG_POOL_LIMIT:  pool_lim_q   <= cfg_data_i;
        dqtc_pkg::CFG_DEV_LIMIT_0: dev_lim_q[0] <= cfg_data_i;
        dqtc_pkg::CFG_DEV_LIMIT_1: dev_lim_q[1] <= cfg_data_i;
        dqtc_pkg::CFG_DEV_LIMIT_2: dev_lim_q[2] <= cfg_data_i;
        dqtc_pkg::CFG_DEV_LIMIT_3: dev_lim_q[3] <= cfg_data_i;
        default: begin
          pool_lim_q <= pool_lim_q;
        end
      endcase
    end
  end

  // Working registers, loaded one stage per state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      dqtc_pkg::FSM_IDLE: begin
        if (accept) begin
          sd_q    <= clamp_dev(s_axis_tdata[1:0]);
          from_q  <= s_axis_tdata[49:2];
          td_q    <= clamp_dev(s_axis_tdata[51:50]);
          to_q    <= s_axis_tdata[99:52];
          apply_q <= s_axis_tuser;
        end
      end
      dqtc_pkg::FSM_RD_DST: begin
        // Source counter arrives; gains come from the captured amounts.
        src_q   <= rd_src;
        pgain_q <= (to_q > from_q) ? (to_q - from_q) : '0;
        if (same_dev) begin
          tgain_q <= (to_q > from_q) ? (to_q - from_q) : '0;
        end else begin
          tgain_q <= to_q;
        end
      end
      dqtc_pkg::FSM_SUM: begin
        dst_q     <= rd_dst;
        dsum_q    <= SW'(rd_dst) + SW'(tgain_q);
        psum_q    <= SW'(pool_q) + SW'(pgain_q);
        src_uf_q  <= has_src && (SW'(src_q) < SW'(from_q));
        pool_uf_q <= (SW'(pool_q) < SW'(from_q));
      end
      dqtc_pkg::FSM_DECIDE: begin
        status_q <= status_d;
        commit_q <= (status_d == dqtc_pkg::STS_OK) && apply_q;
        if ((status_d == dqtc_pkg::STS_OK) && apply_q) begin
          new_src_q  <= src_q - COUNT_BITS'(from_q);
          new_pool_q <= pool_q - COUNT_BITS'(from_q) + COUNT_BITS'(to_q);
          if (same_dev) begin
            new_dst_q <= dst_q - COUNT_BITS'(from_q) + COUNT_BITS'(to_q);
          end else begin
            new_dst_q <= dst_q + COUNT_BITS'(to_q);
          end
        end else begin
          new_src_q  <= src_q;
          new_dst_q  <= dst_q;
          new_pool_q <= pool_q;
        end
      end
      dqtc_pkg::FSM_WR_DST: begin
        if (out_load) begin
          m_data_q <= {5'b0,
                       to_field(new_pool_q),
                       has_dst ? to_field(new_dst_q) : {dqtc_pkg::AmountW{1'b0}},
                       status_q};
        end
      end
      default: begin
        dst_q <= dst_q;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Usage RAM is written only in the write-back states.
  a_we_in_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == dqtc_pkg::FSM_WR_SRC || state_q == dqtc_pkg::FSM_WR_DST))
    else $error("usage RAM written outside write-back");

  // An accepted request starts the read sequence.
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == dqtc_pkg::FSM_RD_DST))
    else $error("accepted request did not start the sequence");

  // Only a passing request commits.
  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_q && (state_q == dqtc_pkg::FSM_WR_SRC || state_q == dqtc_pkg::FSM_WR_DST))
    |-> (status_q == dqtc_pkg::STS_OK))
    else $error("commit with a failing status");

  // The pool counter moves only on a committed result load.
  a_pool_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_load && commit_q) |=> $stable(pool_q))
    else $error("pool counter changed without a commit");

endmodule

>>> rtl/core/dqtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-device usage counters; depends on nothing.
module dqtc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the device quota transfer checker.
// Directed and random transfer requests are checked against a built-in predictor
// of the usage and pool counters. Depends on dqtc_pkg and device_quota_transfer_checker.
`timescale 1ns / 100ps

module tb;
  import dqtc_pkg::*;

  typedef logic [AmountW-1:0] amount_t;
  typedef logic [DevIdxW-1:0] dev_t;

  typedef struct {
    dev_t    src_dev;
    amount_t src_amt;
    dev_t    dst_dev;
    amount_t dst_amt;
    logic    apply;
  } request_t;

  typedef struct {
    status_e status;
    amount_t dest_usage;
    amount_t pool_usage;
  } result_t;

  typedef struct {
    request_t req;
    bit       reconfig;
    bit       typed;
    result_t  res;
  } directed_row_t;

  // How the limits of a random phase are chosen.
  typedef enum {LIM_OPEN, LIM_NEAR, LIM_FULL, LIM_MIXED} limit_style_e;

  localparam amount_t              COUNT_MAX       = '1;
  localparam logic [CfgIdxW-1:0]   CFG_IDX_SPARE   = 3'd7;
  localparam int unsigned          NUM_DEV         = 4;
  localparam int unsigned          RANDOM_ITEMS    = 1650;
  localparam int unsigned          NUM_PHASES      = 6;
  localparam int unsigned          PRESSURE_PHASE  = 4;
  localparam int unsigned          HOLD_OFF_CYCLES = 300;
  localparam int unsigned          DRAIN_CYCLES    = 16;
  localparam int unsigned          CYCLE_LIMIT     = 500000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [LimitW-1:0]     cfg_data_i;

  // Shadow copy of the block state and its limits.
  amount_t dev_bytes [NUM_DEV];
  amount_t pool_bytes;
  amount_t dev_limit_q [NUM_DEV];
  amount_t pool_limit_q;

  result_t       pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned   error_count;
  int unsigned   tx_max_gap;
  int unsigned   rx_max_gap;
  bit            hold_off_request;

  device_quota_transfer_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run-time guard.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic amount_t rand_amount();
    return amount_t'({$urandom, $urandom});
  endfunction

  // Checks one transfer against the shadow counters and commits it when allowed.
  function automatic result_t charge_transfer(request_t r);
    result_t          res;
    logic             has_src;
    logic             has_dst;
    logic             same_dev;
    amount_t          dev_gain;
    amount_t          pool_gain;
    logic [AmountW:0] dev_sum;
    logic [AmountW:0] pool_sum;
    has_src   = (r.src_amt != '0);
    has_dst   = (r.dst_amt != '0);
    same_dev  = has_src && has_dst && (r.src_dev == r.dst_dev);
    pool_gain = (r.dst_amt > r.src_amt) ? r.dst_amt - r.src_amt : '0;
    dev_gain  = same_dev ? pool_gain : r.dst_amt;
    dev_sum   = {1'b0, dev_bytes[r.dst_dev]} + dev_gain;
    pool_sum  = {1'b0, pool_bytes} + pool_gain;

    // Faults first, then the device limit, then the pool limit.
    if (has_src && dev_bytes[r.src_dev] < r.src_amt) begin
      res.status = STS_SRC_UNDERFLOW;
    end else if (pool_bytes < r.src_amt) begin
      res.status = STS_POOL_UNDERFLOW;
    end else if (has_dst && dev_sum[AmountW]) begin
      res.status = STS_DEST_OVERFLOW;
    end else if (pool_sum[AmountW]) begin
      res.status = STS_POOL_OVERFLOW;
    end else if (has_dst && dev_gain != '0 && dev_limit_q[r.dst_dev] != '0 &&
                 dev_sum > dev_limit_q[r.dst_dev]) begin
      res.status = STS_DEST_LIMIT;
    end else if (pool_gain != '0 && pool_limit_q != '0 && pool_sum > pool_limit_q) begin
      res.status = STS_POOL_LIMIT;
    end else begin
      res.status = STS_OK;
    end

    // Commit only accepted requests that ask for it.
    if (res.status == STS_OK && r.apply) begin
      if (same_dev) begin
        dev_bytes[r.dst_dev] = dev_bytes[r.dst_dev] - r.src_amt + r.dst_amt;
      end else begin
        if (has_src) dev_bytes[r.src_dev] = dev_bytes[r.src_dev] - r.src_amt;
        if (has_dst) dev_bytes[r.dst_dev] = dev_bytes[r.dst_dev] + r.dst_amt;
      end
      pool_bytes = pool_bytes - r.src_amt + r.dst_amt;
    end

    res.dest_usage = has_dst ? dev_bytes[r.dst_dev] : '0;
    res.pool_usage = pool_bytes;
    return res;
  endfunction

  // Random request: mostly debits the source can cover, with charges of every size.
  function automatic request_t draw_request();
    request_t    r;
    int unsigned pick;
    amount_t     src_have;
    amount_t     room;
    r.src_dev = dev_t'($urandom_range(0, NUM_DEV - 1));
    r.dst_dev = ($urandom_range(0, 3) == 0) ? r.src_dev : dev_t'($urandom_range(0, NUM_DEV - 1));
    src_have  = dev_bytes[r.src_dev];

    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.src_amt = '0;
    end else if (pick < 75) begin
      r.src_amt = (src_have == '0) ? '0 : rand_amount() % src_have + 1'b1;
    end else if (pick < 90) begin
      r.src_amt = src_have + amount_t'($urandom_range(1, 1000));
    end else begin
      r.src_amt = rand_amount();
    end

    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.dst_amt = '0;
    end else if (pick < 55) begin
      r.dst_amt = amount_t'($urandom_range(1, 1023));
    end else if (pick < 75) begin
      r.dst_amt = amount_t'($urandom_range(1, 1 << 24));
    end else if (pick < 85) begin
      r.dst_amt = rand_amount();
    end else if (pick < 93) begin
      // Right at the edge of the device limit or the counter maximum.
      room = (dev_limit_q[r.dst_dev] > dev_bytes[r.dst_dev]) ?
             dev_limit_q[r.dst_dev] - dev_bytes[r.dst_dev] : COUNT_MAX - dev_bytes[r.dst_dev];
      r.dst_amt = room + amount_t'($urandom_range(0, 2)) - 1'b1;
    end else begin
      // Net charge right at the edge of the pool limit or the counter maximum.
      room = (pool_limit_q > pool_bytes) ? pool_limit_q - pool_bytes : COUNT_MAX - pool_bytes;
      r.dst_amt = room + r.src_amt + amount_t'($urandom_range(0, 2)) - 1'b1;
    end

    r.apply = ($urandom_range(0, 99) < 85);
    return r;
  endfunction

  function automatic amount_t pick_limit(limit_style_e style, amount_t current);
    amount_t headroom;
    limit_style_e chosen;
    headroom = amount_t'($urandom_range(0, 1 << 20));
    chosen   = style;
    if (style == LIM_MIXED) begin
      case ($urandom_range(0, 4))
        0: chosen = LIM_OPEN;
        1: chosen = LIM_FULL;
        2: return rand_amount();
        default: chosen = LIM_NEAR;
      endcase
    end
    case (chosen)
      LIM_OPEN: return '0;
      LIM_FULL: return COUNT_MAX;
      default:  return (current > COUNT_MAX - headroom) ? COUNT_MAX : current + headroom;
    endcase
  endfunction

  // Writes all five limits, then a register index outside the list.
  task automatic write_limits(input amount_t pool_lim, input amount_t lim0, input amount_t lim1,
                              input amount_t lim2, input amount_t lim3);
    amount_t lims [NUM_DEV];
    lims = '{lim0, lim1, lim2, lim3};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_POOL_LIMIT;
    cfg_data_i <= pool_lim;
    @(posedge clk_i);
    pool_limit_q = pool_lim;
    for (int d = 0; d < NUM_DEV; d++) begin
      cfg_idx_i  <= CfgIdxW'(CFG_DEV_LIMIT_0 + d);
      cfg_data_i <= lims[d];
      @(posedge clk_i);
      dev_limit_q[d] = lims[d];
    end
    cfg_idx_i  <= CFG_IDX_SPARE;
    cfg_data_i <= rand_amount();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one request beat and records its expected result once accepted.
  task automatic offer_request(input request_t r, input bit typed, input result_t typed_res);
    int unsigned gap;
    result_t     predicted;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, r.dst_amt, r.dst_dev, r.src_amt, r.src_dev};
    s_axis_tuser  <= r.apply;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = charge_transfer(r);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stops offering and waits until every result is back and the block is quiet.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_row(input dev_t sd, input amount_t sa, input dev_t dd, input amount_t da,
                         input logic ap, input bit reconf, input bit typed,
                         input status_e st, input amount_t du, input amount_t pu);
    directed_row_t row;
    row.req      = '{sd, sa, dd, da, ap};
    row.reconfig = reconf;
    row.typed    = typed;
    row.res      = '{st, du, pu};
    directed_rows.push_back(row);
  endtask

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = $urandom_range(0, rx_max_gap);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Result checker: each beat against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[StatusW-1:0] != exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_res.status, m_axis_tdata[StatusW-1:0]);
          error_count++;
        end
        if (m_axis_tdata[StatusW +: AmountW] != exp_res.dest_usage) begin
          $error("dest_usage mismatch: expected %0d, actual %0d",
                 exp_res.dest_usage, m_axis_tdata[StatusW +: AmountW]);
          error_count++;
        end
        if (m_axis_tdata[StatusW+AmountW +: AmountW] != exp_res.pool_usage) begin
          $error("pool_usage mismatch: expected %0d, actual %0d",
                 exp_res.pool_usage, m_axis_tdata[StatusW+AmountW +: AmountW]);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin
    result_t      no_result;
    limit_style_e styles [NUM_PHASES];
    int unsigned  per_phase;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_POOL_LIMIT;
    cfg_data_i    <= '0;
    error_count      = 0;
    hold_off_request = 1'b0;
    tx_max_gap       = 19;
    rx_max_gap       = 19;
    pool_bytes       = '0;
    pool_limit_q     = '0;
    for (int d = 0; d < NUM_DEV; d++) begin
      dev_bytes[d]   = '0;
      dev_limit_q[d] = '0;
    end
    no_result = '{STS_OK, '0, '0};
    styles    = '{LIM_OPEN, LIM_NEAR, LIM_FULL, LIM_MIXED, LIM_NEAR, LIM_MIXED};
    per_phase = RANDOM_ITEMS / NUM_PHASES;

    // No limits: empty request, underflow, check-only, counters at their maximum.
    add_row(0, 0, 0, 0, 1, 0, 1, STS_OK, 0, 0);
    add_row(1, 5, 0, 0, 1, 0, 1, STS_SRC_UNDERFLOW, 0, 0);
    add_row(3, 0, 2, 100, 0, 0, 1, STS_OK, 0, 0);
    add_row(3, 0, 2, 100, 1, 0, 1, STS_OK, 100, 100);
    add_row(0, 0, 3, COUNT_MAX, 1, 0, 1, STS_POOL_OVERFLOW, 0, 100);
    add_row(2, 100, 3, COUNT_MAX, 1, 0, 1, STS_OK, COUNT_MAX, COUNT_MAX);
    add_row(0, 0, 3, 1, 1, 0, 1, STS_DEST_OVERFLOW, COUNT_MAX, COUNT_MAX);
    add_row(1, 0, 0, 1, 1, 0, 1, STS_POOL_OVERFLOW, 0, COUNT_MAX);
    add_row(3, COUNT_MAX, 3, COUNT_MAX, 1, 0, 1, STS_OK, COUNT_MAX, COUNT_MAX);
    add_row(3, COUNT_MAX, 1, 0, 1, 0, 1, STS_OK, 0, 0);
    // Pool 1000, devices 500, unlimited, maximum and 1: limit hits and same-device nets.
    add_row(1, 0, 0, 500, 1, 1, 1, STS_OK, 500, 500);
    add_row(1, 0, 0, 1, 1, 0, 1, STS_DEST_LIMIT, 500, 500);
    add_row(0, 0, 1, 600, 1, 0, 1, STS_POOL_LIMIT, 0, 500);
    add_row(0, 0, 1, 500, 1, 0, 1, STS_OK, 500, 1000);
    add_row(0, 100, 3, 2, 1, 0, 1, STS_DEST_LIMIT, 0, 1000);
    add_row(0, 100, 0, 150, 1, 0, 1, STS_DEST_LIMIT, 500, 1000);
    add_row(0, 150, 0, 100, 1, 0, 1, STS_OK, 450, 950);
    add_row(1, 501, 2, 0, 1, 0, 1, STS_SRC_UNDERFLOW, 0, 950);
    add_row(1, 500, 0, 50, 0, 0, 1, STS_OK, 450, 950);
    add_row(2, 0, 2, COUNT_MAX, 1, 0, 1, STS_POOL_OVERFLOW, 0, 950);
    add_row(0, 0, 3, 1, 1, 0, 1, STS_OK, 1, 951);
    add_row(3, 1, 2, 1, 1, 0, 1, STS_OK, 1, 951);
    add_row(0, 450, 1, 450, 1, 0, 0, STS_OK, 0, 0);
    add_row(1, 123, 3, 0, 0, 0, 0, STS_OK, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].reconfig) begin
        wait_for_drain();
        write_limits(1000, 500, 0, COUNT_MAX, 1);
      end
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases, each under its own set of limits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_drain();
      write_limits(pick_limit(styles[p], pool_bytes),
                   pick_limit(styles[p], dev_bytes[0]), pick_limit(styles[p], dev_bytes[1]),
                   pick_limit(styles[p], dev_bytes[2]), pick_limit(styles[p], dev_bytes[3]));
      if (p == PRESSURE_PHASE) hold_off_request = 1'b1;
      for (int n = 0; n < per_phase; n++) begin
        // Idle behavior changes every stretch of 64 requests.
        if (n % 64 == 0) begin
          tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
          rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
          if (p == PRESSURE_PHASE && n == 0) tx_max_gap = 0;
        end
        offer_request(draw_request(), 1'b0, no_result);
      end
    end

    wait_for_drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
